// ===== rtl/core/hws_pkg.sv =====
package hws_pkg;

  localparam int WINDOW     = 20;
  localparam int SEQ_MAX_LEN = 4096;

  localparam int RES_W   = 8;
  localparam int POS_W   = 13;
  localparam int THR_W   = 10;
  localparam int MP_W    = 7;
  localparam int SCORE_W = 12;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 10;
  localparam int ODATA_W = 32;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  localparam logic [POS_W-1:0] MAX_POS     = POS_W'(SEQ_MAX_LEN);
  localparam logic [POS_W-1:0] WIN_SPAN    = POS_W'(WINDOW - 1);
  localparam logic [THR_W-1:0] THR_RESET   = THR_W'(500);
  localparam logic [MP_W-1:0]  MP_RESET    = MP_W'(5);
  localparam logic [RES_W-1:0] CODE_FIRST  = 8'h41;
  localparam logic [RES_W-1:0] CODE_LAST   = 8'h5A;

  localparam logic signed [SCORE_W-1:0] UNKNOWN_SCORE = -12'sd1000;

  localparam logic signed [SCORE_W-1:0] SCORE_TABLE [26] = '{
    12'sd616, -12'sd1000, 12'sd680, 12'sd28, 12'sd43, 12'sd1000, 12'sd501,
    12'sd165, 12'sd943, -12'sd1000, 12'sd283, 12'sd943, 12'sd738, 12'sd236,
    -12'sd1000, 12'sd711, 12'sd251, 12'sd0, 12'sd359, 12'sd450, -12'sd1000,
    12'sd825, 12'sd878, -12'sd1000, 12'sd880, -12'sd1000
  };

  typedef enum logic [CIDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MAX_POLAR = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_MARKER  = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t        kind;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             any_found;
    logic             truncated;
    logic             run_end;
  } res_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic advance;
    logic flag;
    logic drop;
  } win_ctrl_t;

  function automatic logic signed [SCORE_W-1:0] hws_score(input logic [RES_W-1:0] code);
    logic [4:0] idx;
    idx = 5'(code - CODE_FIRST);
    if (code >= CODE_FIRST && code <= CODE_LAST) begin
      return SCORE_TABLE[idx];
    end
    return UNKNOWN_SCORE;
  endfunction

endpackage

// ===== rtl/core/hydropathy_window_segment_scan.sv =====
// Each result is written into a four-entry result queue when its residue is accepted
// and is shown on out_tvalid from it. One residue per cycle while the queue has room
// for two entries; a segment that coincides with the end marker pushes two results.
// Reset (rst_n low, synchronous): window cells, counters and queue clear,
// score_threshold returns to 500 and max_polar to 5.
module hydropathy_window_segment_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [hws_pkg::RES_W-1:0]    in_tdata,   // [7:0] residue
  input  logic                         in_tlast,   // seq_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [hws_pkg::ODATA_W-1:0]  out_tdata,  // [12:0] start_pos, [25:13] end_pos,
                                                   // [26] any_found, [27] truncated
  output logic                         out_tuser,  // kind
  output logic                         out_tlast,  // run_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hws_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [hws_pkg::CDATA_W-1:0]  cfg_data
);
  import hws_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [MP_W-1:0]  maxp_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] end_p;
  logic             found_r;
  logic             found_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             in_fire;
  logic             full_seq;
  logic             polar;
  logic             hit;
  logic             space_two;
  logic [1:0]       push_cnt;
  win_ctrl_t        wctrl;
  res_t             seg_res;
  res_t             mark_res;
  res_t             push_a;
  res_t             push_b;
  res_t             out_res;

  assign cfg_ready = 1'b1;
  assign in_tready = space_two;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      maxp_r <= MP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_MAX_POLAR: maxp_r <= cfg_data[MP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    full_seq = pos_r >= MAX_POS;
    polar    = hws_score(in_tdata) < $signed({2'b00, thr_r});
    end_p    = pos_r + POS_W'(1);

    wctrl.advance = in_fire && !full_seq;
    wctrl.flag    = polar;
    wctrl.drop    = in_fire && in_tlast;

    seg_res.kind      = KIND_SEGMENT;
    seg_res.start_pos = end_p - WIN_SPAN;
    seg_res.end_pos   = end_p;
    seg_res.any_found = 1'b0;
    seg_res.truncated = 1'b0;
    seg_res.run_end   = !in_tlast;

    mark_res.kind      = KIND_MARKER;
    mark_res.start_pos = '0;
    mark_res.end_pos   = '0;
    mark_res.any_found = found_r || hit;
    mark_res.truncated = ovf_r || full_seq;
    mark_res.run_end   = 1'b1;

    push_a   = hit ? seg_res : mark_res;
    push_b   = mark_res;
    push_cnt = 2'(hit) + 2'(in_fire && in_tlast);

    pos_nxt   = pos_r;
    found_nxt = found_r || hit;
    ovf_nxt   = ovf_r || (in_fire && full_seq);
    if (wctrl.advance) begin
      pos_nxt = end_p;
    end
    if (wctrl.drop) begin
      pos_nxt   = '0;
      found_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  hws_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (wctrl),
    .max_polar (maxp_r),
    .hit       (hit)
  );

  hws_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (push_b),
    .space_two (space_two),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_res)
  );

  assign out_tdata = ODATA_W'({out_res.truncated, out_res.any_found,
                               out_res.end_pos, out_res.start_pos});
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.run_end;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (pos_r == '0) && !found_r && !ovf_r)
    else $error("sequence state not cleared after end");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("position past maximum length");

  a_hit_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> in_fire && !full_seq)
    else $error("segment without accepted residue");
`endif

endmodule

// ===== rtl/core/hws_cell.sv =====
module hws_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  hws_pkg::cell_ctrl_t ctrl,
  input  logic              flag_in,
  output logic              flag_out
);
  import hws_pkg::*;

  logic flag_r;
  logic flag_nxt;

  always_comb begin
    flag_nxt = flag_r;
    if (ctrl.clear) begin
      flag_nxt = 1'b0;
    end else if (ctrl.shift) begin
      flag_nxt = flag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign flag_out = flag_r;

endmodule

// ===== rtl/core/hws_window.sv =====
module hws_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hws_pkg::win_ctrl_t     ctrl,
  input  logic [hws_pkg::MP_W-1:0] max_polar,
  output logic                   hit
);
  import hws_pkg::*;

  logic [WINDOW-1:0] flags;
  logic [FILL_W-1:0] count_r;
  logic [FILL_W-1:0] count_nxt;
  logic [FILL_W-1:0] count_step;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] fill_step;
  cell_ctrl_t        cctrl;

  always_comb begin
    count_step = count_r - FILL_W'(flags[WINDOW-1]) + FILL_W'(ctrl.flag);
    if (fill_r >= FILL_W'(WINDOW)) begin
      fill_step = FILL_W'(WINDOW);
    end else begin
      fill_step = fill_r + FILL_W'(1);
    end
    hit = ctrl.advance && (fill_step == FILL_W'(WINDOW)) &&
          (MP_W'(count_step) <= max_polar);
    cctrl.shift = ctrl.advance;
    cctrl.clear = hit || ctrl.drop;
    count_nxt = count_r;
    fill_nxt  = fill_r;
    if (cctrl.clear) begin
      count_nxt = '0;
      fill_nxt  = '0;
    end else if (ctrl.advance) begin
      count_nxt = count_step;
      fill_nxt  = fill_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
        hws_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (cctrl),
          .flag_in  (ctrl.flag),
          .flag_out (flags[i])
        );
      end else begin : g_body
        hws_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (cctrl),
          .flag_in  (flags[i-1]),
          .flag_out (flags[i])
        );
      end
    end
  endgenerate

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill above window size");

  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fill_r)
    else $error("polar count exceeds window fill");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == FILL_W'($countones(flags)))
    else $error("polar count out of step with cell flags");

  a_hit_empties: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> (fill_r == '0) && (flags == '0))
    else $error("window not emptied after segment");
`endif

endmodule

// ===== rtl/core/hws_outq.sv =====
module hws_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  hws_pkg::res_t push_a,
  input  hws_pkg::res_t push_b,
  output logic          space_two,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hws_pkg::res_t pop_data
);
  import hws_pkg::*;

  res_t                mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_r;
  logic [OQ_PTR_W-1:0] wp_nxt;
  logic [OQ_PTR_W-1:0] rp_r;
  logic [OQ_PTR_W-1:0] rp_nxt;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;
  logic                pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[rp_r];
  assign space_two = cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2);

  always_comb begin
    wp_nxt  = wp_r + OQ_PTR_W'(push_cnt);
    rp_nxt  = rp_r + OQ_PTR_W'(pop);
    cnt_nxt = cnt_r + OQ_CNT_W'(push_cnt) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_r + OQ_PTR_W'(1)] <= push_b;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    OQ_PTR_W'(wp_r - rp_r) == OQ_PTR_W'(cnt_r))
    else $error("queue pointers disagree with count");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> (cnt_r - OQ_CNT_W'(pop) + OQ_CNT_W'(push_cnt)
                            <= OQ_CNT_W'(OQ_DEPTH)))
    else $error("push into full result queue");
`endif

endmodule
